FILE: design/adsr_pkg.sv
package adsr_pkg;

  // Phase accumulator: Q0.24, one full stage is 2^24
  localparam int PHASE_W = 24;
  localparam int STEP_W  = 25;
  localparam int LEVEL_W = 16;
  localparam int ADDR_W  = 3;

  localparam logic [LEVEL_W-1:0] FULL_LEVEL = 16'd32768;
  localparam logic [STEP_W-1:0]  FULL_PHASE = 25'h100_0000;
  localparam logic signed [LEVEL_W-1:0] GATE_THRESHOLD = 16'sd16384;

  // Reset values of the control registers
  localparam logic [STEP_W-1:0]  ATTACK_STEP_RST  = 25'd12681;
  localparam logic [STEP_W-1:0]  DECAY_STEP_RST   = 25'd38044;
  localparam logic [STEP_W-1:0]  RELEASE_STEP_RST = 25'd3804;
  localparam logic [LEVEL_W-1:0] SUSTAIN_RST      = 16'd26214;

  // Register indexes
  localparam logic [ADDR_W-1:0] REG_ATTACK_STEP  = 3'd0;
  localparam logic [ADDR_W-1:0] REG_DECAY_STEP   = 3'd1;
  localparam logic [ADDR_W-1:0] REG_RELEASE_STEP = 3'd2;
  localparam logic [ADDR_W-1:0] REG_SUSTAIN      = 3'd3;
  localparam logic [ADDR_W-1:0] REG_GATE_ENABLE  = 3'd4;
  localparam logic [ADDR_W-1:0] REG_AUTO_RETRIG  = 3'd5;

  // Command codes carried on tuser
  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_TOGGLE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_ATTACK  = 3'd1,
    ST_DECAY   = 3'd2,
    ST_SUSTAIN = 3'd3,
    ST_RELEASE = 3'd4
  } stage_t;

endpackage

FILE: design/adsr_envelope_generator.sv
// Linear ADSR envelope generator.
// Input stream (s_*): one word per control tick. tuser is the command:
// tick produces one envelope sample, toggle flips the manual gate and
// produces nothing. tdata carries the gate control sample (Q1.15 signed).
// Output stream (m_*): one word per tick, level in Q1.15 (32768 = 1.0) and
// the stage code after the step.
// An accepted tick is registered into the output register, or into the
// skid register while the output is held. One word is accepted every
// cycle while s_tready is high; the stage update and the single 25x16
// multiply for decay/release sit between state and output registers.
// The output register is backed by a one-word skid register, so s_tready
// is a registered signal and only drops after the receiver has stalled
// with both held; it rises again as soon as the skid word moves out.
// Configuration (cfg_*) writes one register per cycle with cfg_we high;
// the user must only change it while no word is in flight (not enforced).
// Reset (synchronous, rst high) returns the envelope to idle with zero
// phase, clears the manual gate, empties both output registers and loads
// the default control register values.
module adsr_envelope_generator (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [24:0] cfg_wdata,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] gate_sample
  input  logic        s_tuser,   // [0] cmd
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [15:0] level, [18:16] stage, [23:19] zero
);

  // control registers
  logic [adsr_pkg::STEP_W-1:0]  attack_step;
  logic [adsr_pkg::STEP_W-1:0]  decay_step;
  logic [adsr_pkg::STEP_W-1:0]  release_step;
  logic [adsr_pkg::LEVEL_W-1:0] sustain_level;
  logic                         gate_enable;
  logic                         auto_retrigger;

  // envelope state
  adsr_pkg::stage_t              env_stage, env_stage_next;
  logic [adsr_pkg::PHASE_W-1:0]  phase, phase_next;
  logic                          manual_gate, manual_gate_next;

  // output and skid registers
  logic                          skid_valid;
  logic [adsr_pkg::LEVEL_W-1:0]  out_level, skid_level;
  adsr_pkg::stage_t              out_stage, skid_stage;

  logic                          accept, is_toggle, new_word, out_take;
  logic signed [15:0]            gate_sample;
  logic                          gate_active;
  logic [adsr_pkg::LEVEL_W-1:0]  sus;
  logic [adsr_pkg::STEP_W-1:0]   step;
  logic [adsr_pkg::STEP_W:0]     phase_sum;
  logic                          stage_done;
  logic [adsr_pkg::STEP_W-1:0]   mul_a;
  logic [adsr_pkg::LEVEL_W-1:0]  mul_b;
  logic [39:0]                   prod;
  logic [adsr_pkg::LEVEL_W-1:0]  prod_hi;
  logic [adsr_pkg::LEVEL_W-1:0]  level_calc;

  assign accept    = s_tvalid && s_tready;
  assign is_toggle = (s_tuser == adsr_pkg::CMD_TOGGLE);
  assign new_word  = accept && !is_toggle;
  assign out_take  = m_tvalid && m_tready;

  // ---------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      attack_step    <= adsr_pkg::ATTACK_STEP_RST;
      decay_step     <= adsr_pkg::DECAY_STEP_RST;
      release_step   <= adsr_pkg::RELEASE_STEP_RST;
      sustain_level  <= adsr_pkg::SUSTAIN_RST;
      gate_enable    <= 1'b0;
      auto_retrigger <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        adsr_pkg::REG_ATTACK_STEP:  attack_step    <= cfg_wdata;
        adsr_pkg::REG_DECAY_STEP:   decay_step     <= cfg_wdata;
        adsr_pkg::REG_RELEASE_STEP: release_step   <= cfg_wdata;
        adsr_pkg::REG_SUSTAIN:      sustain_level  <= cfg_wdata[15:0];
        adsr_pkg::REG_GATE_ENABLE:  gate_enable    <= cfg_wdata[0];
        adsr_pkg::REG_AUTO_RETRIG:  auto_retrigger <= cfg_wdata[0];
        default: ;  // unused index, ignored
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Shared datapath
  // ---------------------------------------------------------------
  // sustain above full scale is clamped
  assign sus = (sustain_level > adsr_pkg::FULL_LEVEL) ? adsr_pkg::FULL_LEVEL
                                                      : sustain_level;

  assign gate_sample = s_tdata;
  assign gate_active = manual_gate ||
                       (gate_enable && (gate_sample > adsr_pkg::GATE_THRESHOLD));

  always_comb begin
    case (env_stage)
      adsr_pkg::ST_ATTACK:  step = attack_step;
      adsr_pkg::ST_DECAY:   step = decay_step;
      default:              step = release_step;
    endcase
  end

  // phase stays below 2^24, so the stage ends when the sum reaches bit 24
  assign phase_sum  = {2'b00, phase} + {1'b0, step};
  assign stage_done = |phase_sum[adsr_pkg::STEP_W:adsr_pkg::PHASE_W];

  // one multiplier serves both falling ramps:
  //   decay:   p * (1.0 - S)
  //   release: (1.0 - p) * S
  always_comb begin
    if (env_stage == adsr_pkg::ST_DECAY) begin
      mul_a = {1'b0, phase};
      mul_b = adsr_pkg::FULL_LEVEL - sus;
    end else begin
      mul_a = adsr_pkg::FULL_PHASE - {1'b0, phase};
      mul_b = sus;
    end
  end

  assign prod    = 40'(mul_a) * 40'(mul_b);
  assign prod_hi = prod[39:24];

  // ---------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------
  always_comb begin
    env_stage_next   = env_stage;
    phase_next       = phase;
    manual_gate_next = manual_gate;
    if (is_toggle) begin
      manual_gate_next = !manual_gate;
      env_stage_next   = manual_gate ? adsr_pkg::ST_RELEASE : adsr_pkg::ST_ATTACK;
      phase_next       = '0;
    end else begin
      case (env_stage)
        adsr_pkg::ST_ATTACK: begin
          if (stage_done) begin
            env_stage_next = adsr_pkg::ST_DECAY;
            phase_next     = '0;
          end else begin
            phase_next = phase_sum[adsr_pkg::PHASE_W-1:0];
          end
        end
        adsr_pkg::ST_DECAY: begin
          if (stage_done) begin
            env_stage_next = adsr_pkg::ST_SUSTAIN;
            phase_next     = '0;
          end else begin
            phase_next = phase_sum[adsr_pkg::PHASE_W-1:0];
          end
        end
        adsr_pkg::ST_SUSTAIN: begin
          if (!gate_active) begin
            env_stage_next = adsr_pkg::ST_RELEASE;
            phase_next     = '0;
          end
        end
        adsr_pkg::ST_RELEASE: begin
          if (stage_done) begin
            env_stage_next = adsr_pkg::ST_IDLE;
            phase_next     = '0;
          end else begin
            phase_next = phase_sum[adsr_pkg::PHASE_W-1:0];
          end
        end
        default: begin
          // idle, and any unused code behaves as idle
          env_stage_next = adsr_pkg::ST_IDLE;
          if (gate_active || auto_retrigger) begin
            env_stage_next = adsr_pkg::ST_ATTACK;
            phase_next     = '0;
          end
        end
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Level output
  // ---------------------------------------------------------------
  always_comb begin
    case (env_stage)
      adsr_pkg::ST_ATTACK:
        level_calc = stage_done ? adsr_pkg::FULL_LEVEL
                                : {1'b0, phase[adsr_pkg::PHASE_W-1:9]};
      adsr_pkg::ST_DECAY:
        level_calc = stage_done ? sus : adsr_pkg::FULL_LEVEL - prod_hi;
      adsr_pkg::ST_SUSTAIN:
        level_calc = sus;
      adsr_pkg::ST_RELEASE:
        level_calc = stage_done ? '0 : prod_hi;
      default:
        level_calc = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      env_stage   <= adsr_pkg::ST_IDLE;
      phase       <= '0;
      manual_gate <= 1'b0;
    end else if (accept) begin
      env_stage   <= env_stage_next;
      phase       <= phase_next;
      manual_gate <= manual_gate_next;
    end
  end

  // ---------------------------------------------------------------
  // Output register with skid word
  // ---------------------------------------------------------------
  assign s_tready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || out_take) begin
      m_tvalid   <= skid_valid || new_word;
      skid_valid <= 1'b0;
    end else if (new_word) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || out_take) begin
      if (skid_valid) begin
        out_level <= skid_level;
        out_stage <= skid_stage;
      end else begin
        out_level <= level_calc;
        out_stage <= env_stage_next;
      end
    end
    if (new_word) begin
      skid_level <= level_calc;
      skid_stage <= env_stage_next;
    end
  end

  assign m_tdata = {5'b00000, out_stage, out_level};

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  // skid word only exists behind a held output word
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid word without output word");

  // a toggle always flips the manual gate
  a_toggle_flips: assert property (@(posedge clk) disable iff (rst)
    (accept && is_toggle) |=> (manual_gate != $past(manual_gate)))
    else $error("toggle did not flip manual gate");

  // idle is only reached with the phase cleared
  a_idle_phase: assert property (@(posedge clk) disable iff (rst)
    (env_stage == adsr_pkg::ST_IDLE) |-> (phase == '0))
    else $error("idle with nonzero phase");

  // level never exceeds full scale
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_level <= adsr_pkg::FULL_LEVEL))
    else $error("level above full scale");

  // a tick taken with room in the output register shows up next cycle
  a_tick_latency: assert property (@(posedge clk) disable iff (rst)
    (new_word && !m_tvalid) |=> m_tvalid)
    else $error("tick result lost");

endmodule
